>>> rtl/core/rdfs_pkg.sv
// ----------------------------------------------------------------------------
// Randomised DFS explorer package
// Shared constants, move codes and the controller to datapath interface types.
// ----------------------------------------------------------------------------
package rdfs_pkg;

    localparam int ROOMS         = 64;
    localparam int ROOM_W        = 6;
    localparam int MAX_NB        = 8;
    localparam int SLOT_W        = 3;
    localparam int NB_CNT_W      = 4;
    localparam int CNT_W         = 16;
    localparam int RND_W         = 16;
    localparam int ENTRY_W       = ROOM_W + 1;
    localparam int ROW_W         = ENTRY_W * MAX_NB;
    localparam int RC_W          = 7;
    localparam int WANDER_FACTOR = 5;
    localparam int DIV_CNT_W     = 4;

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_BACK   = 2'd1,
        KIND_WANDER = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic [1:0] CFG_ROOM_COUNT = 2'd0;
    localparam logic [1:0] CFG_START_ROOM = 2'd1;

    typedef struct packed {
        logic latch;
        logic rd;
        logic load_wr;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic apply;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic scan_last;
        logic div_last;
        logic done;
    } status_t;

endpackage

>>> rtl/core/rdfs_ctrl.sv
// ----------------------------------------------------------------------------
// Randomised DFS explorer controller
// Per beat: read, then a table write or scan, remainder and update; output.
// ----------------------------------------------------------------------------
module rdfs_ctrl
    import rdfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_free,
    input  status_t st,
    output logic    in_ready,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_APPLY,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = st.mode ? S_SCAN : S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

>>> rtl/core/rdfs_dp.sv
// ----------------------------------------------------------------------------
// Randomised DFS explorer datapath
// Adjacency rows, path stack, explored bits, slot scan, serial remainder and
// the walk state with its saturating counters.
// ----------------------------------------------------------------------------
module rdfs_dp
    import rdfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             st,
    input  logic                in_mode,
    input  logic [ROOM_W-1:0]   in_room,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [ROOM_W-1:0]   in_neighbor,
    input  logic                in_slot_used,
    input  logic [RND_W-1:0]    in_random,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [RC_W-1:0]     cfg_data,
    output logic [ROOM_W-1:0]   res_room,
    output kind_t               res_kind,
    output logic                res_error,
    output logic                res_done,
    output logic [CNT_W-1:0]    res_total,
    output logic [CNT_W-1:0]    res_back,
    output logic [CNT_W-1:0]    res_wander
);

    logic                 mode_reg;
    logic [ROOM_W-1:0]    room_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [ROOM_W-1:0]    nb_reg;
    logic                 used_reg;
    logic [RND_W-1:0]     rnd_reg;

    logic [RC_W-1:0]      room_count_reg;
    logic                 started_reg;

    logic [ROW_W-1:0]     adj_mem [ROOMS];
    logic [ROW_W-1:0]     adj_q_reg;
    logic [ROOMS-1:0]     row_valid_reg;
    logic                 row_ok_reg;
    logic [ROOM_W-1:0]    stk_mem [ROOMS];
    logic [ROOM_W-1:0]    stk_q_reg;

    logic [ROOMS-1:0]     explored_reg;
    logic [RC_W-1:0]      depth_reg;
    logic [ROOM_W-1:0]    here_reg;
    logic [RC_W-1:0]      exp_cnt_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     back_reg;
    logic [CNT_W-1:0]     wander_reg;
    logic                 done_reg;
    kind_t                kind_reg;
    logic                 err_reg;

    logic [SLOT_W-1:0]    idx_reg;
    logic [NB_CNT_W-1:0]  nf_reg;
    logic [NB_CNT_W-1:0]  nv_reg;
    logic [ROOM_W-1:0]    fresh_reg [MAX_NB];
    logic [ROOM_W-1:0]    valid_reg [MAX_NB];

    logic [NB_CNT_W-1:0]  dvs_reg;
    logic [NB_CNT_W-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    logic [ROW_W-1:0]     row_sel;
    logic [ROW_W-1:0]     row_new;
    logic [ENTRY_W-1:0]   entry;
    logic [ROOM_W-1:0]    rd_addr;
    logic [NB_CNT_W:0]    rem_shift;
    logic [RC_W-1:0]      limit;
    logic [RC_W+1:0]      limit5;
    logic [SLOT_W-1:0]    pick;
    logic                 do_push;
    logic [ROOM_W-1:0]    here_next;
    logic [RC_W-1:0]      depth_next;
    logic [RC_W-1:0]      exp_cnt_next;
    logic [CNT_W-1:0]     total_next;
    logic [CNT_W-1:0]     back_next;
    logic [CNT_W-1:0]     wander_next;
    logic                 mark_next;
    kind_t                kind_next;
    logic                 err_next;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    assign rd_addr = mode_reg ? here_reg : room_reg;
    assign row_sel = row_ok_reg ? adj_q_reg : '0;
    assign entry   = row_sel[idx_reg*ENTRY_W +: ENTRY_W];

    always_comb
    begin
        row_new = row_sel;
        row_new[slot_reg*ENTRY_W +: ENTRY_W] = {used_reg, nb_reg};
    end

    assign rem_shift = {rem_reg, rnd_reg[RND_W-1 - dcnt_reg]};

    always_comb
    begin
        if (room_count_reg == '0)
            limit = RC_W'(1);
        else if (room_count_reg > RC_W'(ROOMS))
            limit = RC_W'(ROOMS);
        else
            limit = room_count_reg;
        limit5 = (RC_W+2)'(limit) * (RC_W+2)'(WANDER_FACTOR);
    end

    assign pick = rem_reg[SLOT_W-1:0];

    always_comb
    begin
        here_next    = here_reg;
        depth_next   = depth_reg;
        exp_cnt_next = exp_cnt_reg;
        total_next   = total_reg;
        back_next    = back_reg;
        wander_next  = wander_reg;
        mark_next    = 1'b0;
        do_push      = 1'b0;
        kind_next    = KIND_NONE;
        err_next     = 1'b0;
        if (nf_reg != '0)
        begin
            do_push   = (depth_reg < RC_W'(ROOMS));
            if (do_push)
                depth_next = depth_reg + 1'b1;
            here_next = fresh_reg[pick];
            if (!explored_reg[fresh_reg[pick]])
            begin
                mark_next    = 1'b1;
                exp_cnt_next = exp_cnt_reg + 1'b1;
            end
            total_next = bump(total_reg);
            kind_next  = KIND_NEW;
        end
        else if (depth_reg != '0)
        begin
            depth_next = depth_reg - 1'b1;
            here_next  = stk_q_reg;
            total_next = bump(total_reg);
            back_next  = bump(back_reg);
            kind_next  = KIND_BACK;
        end
        else if (nv_reg != '0)
        begin
            here_next   = valid_reg[pick];
            total_next  = bump(total_reg);
            wander_next = bump(wander_reg);
            kind_next   = KIND_WANDER;
        end
        else
        begin
            err_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= in_mode;
            room_reg <= in_room;
            slot_reg <= in_slot;
            nb_reg   <= in_neighbor;
            used_reg <= in_slot_used;
            rnd_reg  <= in_random;
        end
        if (cmd.rd)
        begin
            adj_q_reg <= adj_mem[rd_addr];
            stk_q_reg <= stk_mem[depth_reg[ROOM_W-1:0] - 1'b1];
        end
        if (cmd.load_wr)
            adj_mem[room_reg] <= row_new;
        if (cmd.apply && do_push)
            stk_mem[depth_reg[ROOM_W-1:0]] <= here_reg;
        if (cmd.scan_step && entry[ROOM_W])
        begin
            valid_reg[nv_reg[SLOT_W-1:0]] <= entry[ROOM_W-1:0];
            if (!explored_reg[entry[ROOM_W-1:0]])
                fresh_reg[nf_reg[SLOT_W-1:0]] <= entry[ROOM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_count_reg <= RC_W'(ROOMS);
            started_reg    <= 1'b0;
            row_valid_reg  <= '0;
            row_ok_reg     <= 1'b0;
            explored_reg   <= '0;
            depth_reg      <= '0;
            here_reg       <= '0;
            exp_cnt_reg    <= '0;
            total_reg      <= '0;
            back_reg       <= '0;
            wander_reg     <= '0;
            done_reg       <= 1'b0;
            kind_reg       <= KIND_NONE;
            err_reg        <= 1'b0;
            idx_reg        <= '0;
            nf_reg         <= '0;
            nv_reg         <= '0;
            dvs_reg        <= '0;
            rem_reg        <= '0;
            dcnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROOM_COUNT)
                    room_count_reg <= cfg_data;
                else if (cfg_index == CFG_START_ROOM)
                begin
                    if (!started_reg)
                        here_reg <= cfg_data[ROOM_W-1:0];
                end
            end
            if (cmd.rd)
            begin
                row_ok_reg <= row_valid_reg[rd_addr];
                idx_reg    <= '0;
                nf_reg     <= '0;
                nv_reg     <= '0;
            end
            if (cmd.load_wr)
            begin
                row_valid_reg[room_reg] <= 1'b1;
                kind_reg                <= KIND_NONE;
                err_reg                 <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (entry[ROOM_W])
                begin
                    nv_reg <= nv_reg + 1'b1;
                    if (!explored_reg[entry[ROOM_W-1:0]])
                        nf_reg <= nf_reg + 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                dvs_reg  <= (nf_reg != '0) ? nf_reg : nv_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (rem_shift >= {1'b0, dvs_reg})
                    rem_reg <= NB_CNT_W'(rem_shift - {1'b0, dvs_reg});
                else
                    rem_reg <= rem_shift[NB_CNT_W-1:0];
            end
            if (cmd.apply)
            begin
                started_reg <= 1'b1;
                here_reg    <= here_next;
                depth_reg   <= depth_next;
                exp_cnt_reg <= exp_cnt_next;
                total_reg   <= total_next;
                back_reg    <= back_next;
                wander_reg  <= wander_next;
                kind_reg    <= kind_next;
                err_reg     <= err_next;
                if (mark_next)
                    explored_reg[here_next] <= 1'b1;
                if ((exp_cnt_next == limit) || (wander_next > CNT_W'(limit5)))
                    done_reg <= 1'b1;
            end
        end
    end

    assign st.mode      = mode_reg;
    assign st.scan_last = (idx_reg == SLOT_W'(MAX_NB - 1));
    assign st.div_last  = (dcnt_reg == DIV_CNT_W'(RND_W - 1));
    assign st.done      = done_reg;

    assign res_room   = here_reg;
    assign res_kind   = kind_reg;
    assign res_error  = err_reg;
    assign res_done   = done_reg;
    assign res_total  = total_reg;
    assign res_back   = back_reg;
    assign res_wander = wander_reg;

endmodule

>>> rtl/core/random_dfs_graph_explorer.sv
// ----------------------------------------------------------------------------
// Randomised depth-first graph explorer
// Loads an adjacency table one slot per beat and walks the room graph one
// step per beat, reporting the room, the kind of move and the move counters.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// s_axis   in         s_tvalid/s_tready   s_tdata (32 bits), s_tuser (mode)
// m_axis   out        m_tvalid/m_tready   m_tdata (56 bits), m_tuser (move)
// cfg      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load beat goes through read, table write and output, and a step beat
// through read, the eight-slot scan, the bit-serial remainder over the random
// value, update and output. One beat is worked on at a time, and the next one
// can be accepted in the cycle after the result is registered. The result
// register lets the next beat be accepted while a result waits. Reset clears
// the adjacency rows through per-row valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module random_dfs_graph_explorer
    import rdfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // room, slot, neighbor, slot_used, random_value
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // occupied room, error, done_res, steps_total,
                                   // steps_back, steps_wander
    output logic [1:0]  m_tuser,   // move_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    cmd_t               cmd;
    status_t            st;
    logic               out_free;
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic [1:0]         m_user_reg;
    logic [ROOM_W-1:0]  res_room;
    kind_t              res_kind;
    logic               res_error;
    logic               res_done;
    logic [CNT_W-1:0]   res_total;
    logic [CNT_W-1:0]   res_back;
    logic [CNT_W-1:0]   res_wander;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    rdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rdfs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_mode      (s_tuser),
        .in_room      (s_tdata[5:0]),
        .in_slot      (s_tdata[8:6]),
        .in_neighbor  (s_tdata[14:9]),
        .in_slot_used (s_tdata[15]),
        .in_random    (s_tdata[31:16]),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res_room     (res_room),
        .res_kind     (res_kind),
        .res_error    (res_error),
        .res_done     (res_done),
        .res_total    (res_total),
        .res_back     (res_back),
        .res_wander   (res_wander)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_data_reg <= {res_wander, res_back, res_total, res_done, res_error, res_room};
            m_user_reg <= res_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in progress");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st.done |=> st.done)
        else $error("done flag cleared");

    a_error_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> m_tuser == KIND_NONE)
        else $error("error reported with a move");

endmodule
